[rtl/core/blm_pkg.sv]
package blm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 18;
    localparam int VOLT_W   = 12;
    localparam int CHARGE_W = 11;
    localparam int FILT_W   = 8;
    localparam int CFG_IDX_W = 2;

    // centivolts = floor(mean * 495 / 512)
    localparam int VOLT_MUL_W = 9;
    localparam logic [VOLT_MUL_W-1:0] VOLT_MUL = 9'd495;
    localparam int VOLT_SHIFT = 9;

    // floor(x / 3) = (x * 2731) >> 13 for x < 8192
    localparam int DIV3_MUL_W = 12;
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 12'd2731;
    localparam int DIV3_SHIFT = 13;

    localparam logic [CFG_IDX_W-1:0] REG_WARNING_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LEVEL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT  = 2'd2;

    localparam logic [VOLT_W-1:0] WARNING_RESET = 12'd1100;
    localparam logic [VOLT_W-1:0] BASE_RESET    = 12'd1000;
    localparam logic [FILT_W-1:0] FILTER_RESET  = 8'd3;

    typedef struct packed {
        logic [VOLT_W-1:0] warning_level;
        logic [VOLT_W-1:0] base_level;
        logic [FILT_W-1:0] filter_count;
    } t_cfg;

    typedef struct packed {
        logic [VOLT_W-1:0]   voltage_centivolts;
        logic [CHARGE_W-1:0] remaining_charge;
        logic                low_battery;
    } t_result;

endpackage

[rtl/core/blm_accum.sv]
module blm_accum
    import blm_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 50
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SUM_W-1:0]    o_sum
);

    localparam int IDX_W = 6;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_READING - 1);

    logic [SUM_W-1:0] r_sum, n_sum;
    logic [IDX_W-1:0] r_index;
    logic [SUM_W-1:0] r_block_sum;
    logic             r_block_valid;
    logic             w_last, w_take;

    assign w_last  = (r_index == LAST_IDX);
    // only the last sample of a block needs room in the block register
    assign o_ready = !w_last || !r_block_valid || i_ready;
    assign w_take  = i_valid && o_ready;
    assign n_sum   = r_sum + SUM_W'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum         <= '0;
            r_index       <= '0;
            r_block_valid <= 1'b0;
        end else begin
            if (r_block_valid && i_ready) begin
                r_block_valid <= 1'b0;
            end
            if (w_take) begin
                if (w_last) begin
                    r_sum         <= '0;
                    r_index       <= '0;
                    r_block_valid <= 1'b1;
                end else begin
                    r_sum   <= n_sum;
                    r_index <= r_index + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_last) begin
            r_block_sum <= n_sum;
        end
    end

    assign o_valid = r_block_valid;
    assign o_sum   = r_block_sum;

endmodule

[rtl/core/blm_scale.sv]
module blm_scale
    import blm_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 50
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SUM_W-1:0]  i_sum,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [VOLT_W-1:0] o_volts
);

    // floor(sum / N) as (sum * ceil(2^K / N)) >> K, exact for any 18-bit sum
    localparam int RECIP_SHIFT = SUM_W + 7;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int VPROD_W = SUM_W + VOLT_MUL_W;

    logic               r_mean_valid, r_volt_valid;
    logic [SUM_W-1:0]   r_mean;
    logic [VOLT_W-1:0]  r_volts;
    logic [PROD_W-1:0]  w_mean_prod;
    logic [VPROD_W-1:0] w_volt_prod;
    logic               w_volt_ready, w_mean_ready;

    assign w_volt_ready = !r_volt_valid || i_ready;
    assign w_mean_ready = !r_mean_valid || w_volt_ready;
    assign o_ready      = w_mean_ready;

    assign w_mean_prod = PROD_W'(i_sum) * PROD_W'(RECIP);
    assign w_volt_prod = VPROD_W'(r_mean) * VPROD_W'(VOLT_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean_valid <= 1'b0;
            r_volt_valid <= 1'b0;
        end else begin
            if (w_mean_ready) begin
                r_mean_valid <= i_valid;
            end
            if (w_volt_ready) begin
                r_volt_valid <= r_mean_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mean_ready && i_valid) begin
            r_mean <= w_mean_prod[RECIP_SHIFT +: SUM_W];
        end
        if (w_volt_ready && r_mean_valid) begin
            r_volts <= w_volt_prod[VOLT_SHIFT +: VOLT_W];
        end
    end

    assign o_valid = r_volt_valid;
    assign o_volts = r_volts;

endmodule

[rtl/core/blm_status.sv]
module blm_status
    import blm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [VOLT_W-1:0] i_volts,
    output logic              o_valid,
    input  logic              i_ready,
    output t_result           o_result
);

    localparam int CPROD_W = VOLT_W + DIV3_MUL_W;

    logic              r_out_valid;
    t_result           r_result;
    logic [FILT_W-1:0] r_low_run, r_normal_run, n_low_run, n_normal_run;
    logic              r_fault, n_fault;
    logic [VOLT_W-1:0] w_diff;
    logic [CPROD_W-1:0] w_charge_prod;
    logic [CHARGE_W-1:0] w_charge;
    logic              w_below_base, w_low, w_take;
    logic [FILT_W-1:0] w_low_inc, w_normal_inc;

    assign o_ready = !r_out_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    assign w_below_base  = (i_volts < i_cfg.base_level);
    assign w_diff        = i_volts - i_cfg.base_level;
    assign w_charge_prod = CPROD_W'(w_diff) * CPROD_W'(DIV3_MUL);
    assign w_charge      = w_below_base ? '0 : w_charge_prod[DIV3_SHIFT +: CHARGE_W];

    assign w_low        = (i_volts < i_cfg.warning_level);
    assign w_low_inc    = r_low_run + 1'b1;
    assign w_normal_inc = r_normal_run + 1'b1;

    always_comb begin
        n_low_run    = r_low_run;
        n_normal_run = r_normal_run;
        n_fault      = r_fault;
        if (w_low) begin
            n_normal_run = '0;
            n_low_run    = w_low_inc;
            if (w_low_inc > i_cfg.filter_count) begin
                n_fault   = 1'b1;
                n_low_run = '0;
            end
        end else begin
            n_low_run    = '0;
            n_normal_run = w_normal_inc;
            if (w_normal_inc > i_cfg.filter_count) begin
                n_fault      = 1'b0;
                n_normal_run = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_low_run    <= '0;
            r_normal_run <= '0;
            r_fault      <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (w_take) begin
                r_low_run    <= n_low_run;
                r_normal_run <= n_normal_run;
                r_fault      <= n_fault;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result.voltage_centivolts <= i_volts;
            r_result.remaining_charge   <= w_charge;
            r_result.low_battery        <= n_fault;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

[rtl/core/battery_level_monitor.sv]
// channel   | direction | handshake                     | payload
// ----------+-----------+-------------------------------+-------------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata: sample
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: voltage, charge; tuser: flag
// cfg       | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// one sample is taken per cycle while s_axis_tready is high; a reading leaves three register
// stages after the last sample of its block (block sum, mean, centivolts), then the output register.
// i_rst_n is synchronous and clears sum, sample count, debounce state, valid flags and config registers.
// a stalled m_axis fills the stages; s_axis keeps accepting samples until the
// last sample of a block finds the block register still occupied.
module battery_level_monitor
    import blm_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 50
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,  // [11:0] sample
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,  // [11:0] voltage_centivolts, [22:12] remaining_charge
    output logic                 m_axis_tuser,  // [0] low_battery
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VOLT_W-1:0]    i_cfg_data
);

    t_cfg              r_cfg;
    logic              w_sum_valid, w_sum_ready, w_volt_valid, w_volt_ready;
    logic [SUM_W-1:0]  w_sum;
    logic [VOLT_W-1:0] w_volts;
    t_result           w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warning_level <= WARNING_RESET;
            r_cfg.base_level    <= BASE_RESET;
            r_cfg.filter_count  <= FILTER_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WARNING_LEVEL: r_cfg.warning_level <= i_cfg_data;
                REG_BASE_LEVEL:    r_cfg.base_level    <= i_cfg_data;
                REG_FILTER_COUNT:  r_cfg.filter_count  <= i_cfg_data[FILT_W-1:0];
                default: ;
            endcase
        end
    end

    blm_accum #(
        .SAMPLES_PER_READING(SAMPLES_PER_READING)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample (s_axis_tdata[SAMPLE_W-1:0]),
        .o_valid  (w_sum_valid),
        .i_ready  (w_sum_ready),
        .o_sum    (w_sum)
    );

    blm_scale #(
        .SAMPLES_PER_READING(SAMPLES_PER_READING)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sum_valid),
        .o_ready (w_sum_ready),
        .i_sum   (w_sum),
        .o_valid (w_volt_valid),
        .i_ready (w_volt_ready),
        .o_volts (w_volts)
    );

    blm_status u_status (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_volt_valid),
        .o_ready  (w_volt_ready),
        .i_volts  (w_volts),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {1'b0, w_result.remaining_charge, w_result.voltage_centivolts};
    assign m_axis_tuser = w_result.low_battery;

endmodule
